/* design/slru_pkg.sv */
// Package for the segmented LRU replacement engine.
// It holds the transaction payload types, the register map and the control structs
// passed between the top level and the slot cells. It depends on nothing.
package slru_pkg;

    localparam int BLOCK_W = 40;
    localparam int SLOT_W  = 6;
    localparam int CAP_W   = 7;

    localparam logic FUNC_ACCESS = 1'b0;
    localparam logic FUNC_INVAL  = 1'b1;

    localparam logic REG_PROT_CAP = 1'b0;
    localparam logic REG_PROB_CAP = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd32;

    typedef struct packed {
        logic               func;
        logic [BLOCK_W-1:0] block_index;
        logic               write_dirty;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic               was_protected;
        logic [SLOT_W-1:0]  slot;
        logic               victim_valid;
        logic [BLOCK_W-1:0] victim_index;
        logic               victim_dirty;
    } rsp_t;

    // Broadcast update to all cells. Cell A takes the new entry fields, cell D
    // is demoted to the probationary head, and every other valid cell moves
    // its rank by the increment and decrement of its own segment.
    typedef struct packed {
        logic upd;
        logic a_valid;
        logic a_prot;
        logic a_fill;
        logic a_dirty_keep;
        logic a_dirty_set;
        logic inc_prob;
        logic inc_prot;
        logic dec_prob;
        logic dec_prot;
    } slru_cmd_t;

    typedef struct packed {
        logic match;
        logic free;
        logic tail_prob;
        logic tail_prot;
        logic prot;
        logic dirty;
    } slru_stat_t;

endpackage

/* design/segmented_lru_cache_policy.sv */
// Top level of the segmented LRU replacement engine: sequencer, counts, registers.
// Depends on slru_pkg and instantiates one slru_cell per slot.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  request  | req_valid, req_stall | req  (func, block_index, write_dirty)
//  response | rsp_valid, rsp_stall | rsp  (hit .. victim_dirty)
//  config   | psel, penable, pready| paddr, pwdata, prdata
//
// A request passes through the idle state, in which it is accepted, the look state for
// the tag compare and tail search in all cells, and the update state to apply the list
// update. The response register loads when the update fires, and the next request is
// taken back in idle. The update waits while an earlier response is still stalled.
// Each cell keeps its recency rank, so no pointer walk is needed.
// Reset clears all valid marks, counts and ranks at once; capacities return to 32.
module segmented_lru_cache_policy
    import slru_pkg::*;
#(
    parameter int NUM_SLOTS = 64,
    parameter int TAG_BITS  = 40
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int RW = SW;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int MW = (CW > CAP_W) ? CW : CAP_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic                func_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic                wd_reg;
    logic [CAP_W-1:0]    cap_prot_reg, cap_prob_reg;
    logic [CW-1:0]       cnt_prob_reg, cnt_prob_next;
    logic [CW-1:0]       cnt_prot_reg, cnt_prot_next;
    logic [NUM_SLOTS-1:0] match_oh_reg, free_oh_reg, ptail_oh_reg, rtail_oh_reg;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg, rsp_next;

    slru_stat_t          stat [NUM_SLOTS];
    logic [RW-1:0]       cell_rank [NUM_SLOTS];
    logic [TAG_BITS-1:0] cell_tag [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] match_vec, free_vec, ptail_vec, rtail_vec;

    slru_cmd_t            cmd;
    logic [NUM_SLOTS-1:0] sel_a, sel_d;
    logic [RW-1:0]        thr_prob, thr_prot;
    logic                 fire, accept, cfg_wr;

    // Gathered fields of the hit cell and of the chosen victim.
    logic [SW-1:0]       f_idx, v_idx;
    logic [RW-1:0]       f_rank;
    logic                f_prot, v_prot, v_dirty, hit, any_free;
    logic [TAG_BITS-1:0] v_tag;
    logic                demote, full_prob, evict;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign fire      = (state_reg == ST_UPD) && (!rsp_valid_reg || !rsp_stall);
    assign cfg_wr    = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_PROB_CAP) ? 32'(cap_prob_reg) : 32'(cap_prot_reg);

    genvar g;
    generate
        for (g = 0; g < NUM_SLOTS; g++)
        begin : g_cell
            slru_cell #(
                .TAG_BITS (TAG_BITS),
                .RW       (RW)
            ) u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .cmd            (cmd),
                .sel_a          (sel_a[g]),
                .sel_d          (sel_d[g]),
                .req_tag        (tag_reg),
                .thr_prob       (thr_prob),
                .thr_prot       (thr_prot),
                .tail_rank_prob (RW'(cnt_prob_reg - CW'(1))),
                .tail_rank_prot (RW'(cnt_prot_reg - CW'(1))),
                .stat           (stat[g]),
                .rank           (cell_rank[g]),
                .tag            (cell_tag[g])
            );
            assign match_vec[g] = stat[g].match;
            assign free_vec[g]  = stat[g].free;
            assign ptail_vec[g] = stat[g].tail_prob;
            assign rtail_vec[g] = stat[g].tail_prot;
        end
    endgenerate

    // Decision for the registered lookup results.
    always_comb
    begin
        logic [NUM_SLOTS-1:0] v_oh;
        f_idx   = '0;
        f_rank  = '0;
        f_prot  = 1'b0;
        v_idx   = '0;
        v_prot  = 1'b0;
        v_dirty = 1'b0;
        v_tag   = '0;
        hit      = |match_oh_reg;
        any_free = |free_oh_reg;
        demote    = (MW'(cnt_prot_reg) >= MW'(cap_prot_reg)) && (cnt_prot_reg != '0);
        full_prob = (MW'(cnt_prob_reg) >= MW'(cap_prob_reg)) && (cnt_prob_reg != '0);
        evict     = full_prob || !any_free;
        if (full_prob || (!any_free && cnt_prob_reg != '0))
            v_oh = ptail_oh_reg;
        else if (any_free)
            v_oh = free_oh_reg;
        else
            v_oh = rtail_oh_reg;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (match_oh_reg[i])
            begin
                f_idx  = f_idx | SW'(i);
                f_rank = f_rank | cell_rank[i];
                f_prot = f_prot | stat[i].prot;
            end
            if (v_oh[i])
            begin
                v_idx   = v_idx | SW'(i);
                v_prot  = v_prot | stat[i].prot;
                v_dirty = v_dirty | stat[i].dirty;
                v_tag   = v_tag | cell_tag[i];
            end
        end

        cmd           = '0;
        cmd.upd       = fire;
        sel_a         = '0;
        sel_d         = '0;
        thr_prob      = f_rank;
        thr_prot      = f_rank;
        cnt_prob_next = cnt_prob_reg;
        cnt_prot_next = cnt_prot_reg;
        rsp_next      = '0;

        if (func_reg == FUNC_INVAL)
        begin
            if (hit)
            begin
                sel_a        = match_oh_reg;
                cmd.dec_prob = !f_prot;
                cmd.dec_prot = f_prot;
                if (f_prot)
                    cnt_prot_next = cnt_prot_reg - CW'(1);
                else
                    cnt_prob_next = cnt_prob_reg - CW'(1);
                rsp_next.hit           = 1'b1;
                rsp_next.was_protected = f_prot;
                rsp_next.slot          = SLOT_W'(f_idx);
            end
        end
        else if (hit)
        begin
            sel_a            = match_oh_reg;
            cmd.a_valid      = 1'b1;
            cmd.a_prot       = 1'b1;
            cmd.a_dirty_keep = 1'b1;
            cmd.a_dirty_set  = wd_reg;
            cmd.inc_prot     = 1'b1;
            if (f_prot)
            begin
                cmd.dec_prot = 1'b1;
            end
            else
            begin
                cmd.dec_prob  = 1'b1;
                cmd.inc_prob  = demote;
                sel_d         = demote ? rtail_oh_reg : '0;
                cnt_prob_next = cnt_prob_reg - CW'(1) + CW'(demote);
                cnt_prot_next = cnt_prot_reg + CW'(1) - CW'(demote);
            end
            rsp_next.hit           = 1'b1;
            rsp_next.was_protected = f_prot;
            rsp_next.slot          = SLOT_W'(f_idx);
        end
        else
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (v_idx == SW'(i))
                    sel_a[i] = 1'b1;
            end
            cmd.a_valid     = 1'b1;
            cmd.a_fill      = 1'b1;
            cmd.a_dirty_set = wd_reg;
            cmd.inc_prob    = 1'b1;
            cnt_prob_next   = cnt_prob_reg + CW'(1);
            if (evict)
            begin
                if (v_prot)
                    cnt_prot_next = cnt_prot_reg - CW'(1);
                else
                    cnt_prob_next = cnt_prob_reg;
                rsp_next.victim_valid = 1'b1;
                rsp_next.victim_index = BLOCK_W'(v_tag);
                rsp_next.victim_dirty = v_dirty;
            end
            rsp_next.slot = SLOT_W'(v_idx);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_LOOK;
            ST_LOOK: state_next = ST_UPD;
            ST_UPD:  if (fire) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_prot_reg  <= CAP_RESET;
            cap_prob_reg  <= CAP_RESET;
            cnt_prob_reg  <= '0;
            cnt_prot_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr && paddr[2] == REG_PROT_CAP)
                cap_prot_reg <= pwdata[CAP_W-1:0];
            if (cfg_wr && paddr[2] == REG_PROB_CAP)
                cap_prob_reg <= pwdata[CAP_W-1:0];
            if (fire)
            begin
                cnt_prob_reg  <= cnt_prob_next;
                cnt_prot_reg  <= cnt_prot_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= req.func;
            tag_reg  <= TAG_BITS'(req.block_index);
            wd_reg   <= req.write_dirty;
        end
        if (state_reg == ST_LOOK)
        begin
            match_oh_reg <= match_vec;
            free_oh_reg  <= free_vec & (~free_vec + NUM_SLOTS'(1));
            ptail_oh_reg <= ptail_vec;
            rtail_oh_reg <= rtail_vec;
        end
        if (fire)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* design/slru_cell.sv */
// One slot of the replacement engine: tag, valid, dirty, segment and recency rank.
// Depends on slru_pkg for the command and status structs.
module slru_cell
    import slru_pkg::*;
#(
    parameter int TAG_BITS = 40,
    parameter int RW       = 6
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  slru_cmd_t           cmd,
    input  logic                sel_a,
    input  logic                sel_d,
    input  logic [TAG_BITS-1:0] req_tag,
    input  logic [RW-1:0]       thr_prob,
    input  logic [RW-1:0]       thr_prot,
    input  logic [RW-1:0]       tail_rank_prob,
    input  logic [RW-1:0]       tail_rank_prot,
    output slru_stat_t          stat,
    output logic [RW-1:0]       rank,
    output logic [TAG_BITS-1:0] tag
);

    logic                valid_reg, valid_next;
    logic                prot_reg, prot_next;
    logic                dirty_reg, dirty_next;
    logic [RW-1:0]       rank_reg, rank_next;
    logic [TAG_BITS-1:0] tag_reg;
    logic                inc, dec;

    always_comb
    begin
        inc = prot_reg ? cmd.inc_prot : cmd.inc_prob;
        dec = prot_reg ? (cmd.dec_prot && (rank_reg > thr_prot))
                       : (cmd.dec_prob && (rank_reg > thr_prob));
        valid_next = valid_reg;
        prot_next  = prot_reg;
        dirty_next = dirty_reg;
        rank_next  = rank_reg;
        if (cmd.upd)
        begin
            if (sel_a)
            begin
                valid_next = cmd.a_valid;
                prot_next  = cmd.a_prot;
                dirty_next = (cmd.a_dirty_keep & dirty_reg) | cmd.a_dirty_set;
                rank_next  = '0;
            end
            else if (sel_d)
            begin
                prot_next = 1'b0;
                rank_next = '0;
            end
            else if (valid_reg)
            begin
                rank_next = rank_reg + RW'(inc) - RW'(dec);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            prot_reg  <= 1'b0;
            dirty_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            prot_reg  <= prot_next;
            dirty_reg <= dirty_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.upd && sel_a && cmd.a_fill)
        begin
            tag_reg <= req_tag;
        end
    end

    always_comb
    begin
        stat.match     = valid_reg && (tag_reg == req_tag);
        stat.free      = !valid_reg;
        stat.tail_prob = valid_reg && !prot_reg && (rank_reg == tail_rank_prob);
        stat.tail_prot = valid_reg && prot_reg && (rank_reg == tail_rank_prot);
        stat.prot      = prot_reg;
        stat.dirty     = dirty_reg;
    end

    assign rank = rank_reg;
    assign tag  = tag_reg;

endmodule

/* design/slru_checker.sv */
// Port-level checks for the segmented LRU replacement engine, bound to the top level.
// Depends on slru_pkg for the payload types.
module slru_checker
    import slru_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_stall,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input rsp_t        rsp
);

    // A stalled response transaction holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    // Only one request is in flight at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while busy");

    a_victim_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.victim_valid |-> !rsp.hit)
        else $error("victim reported on a hit");

    a_prot_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.hit |-> !rsp.was_protected)
        else $error("protected flag on a miss");

    a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.victim_valid |-> rsp.victim_index == '0 && !rsp.victim_dirty)
        else $error("victim fields set without a victim");

endmodule

bind segmented_lru_cache_policy slru_checker u_slru_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
